// ===== rtl/core/led_jitter_blend_core_assert.svh =====
// Assertion macros for the jitter blend core checker.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef LED_JITTER_BLEND_CORE_ASSERT_SVH
`define LED_JITTER_BLEND_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define LJB_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ljb assertion failed");

// Next-cycle implication, disabled while in reset.
`define LJB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ljb assertion failed");

`endif

// ===== rtl/core/ljb_pkg.sv =====
// Shared constants, types and arithmetic helpers for the jitter blend core.
// No dependencies; all other source files but the assertion header refer to it by scoped names.
package ljb_pkg;

    // field widths
    localparam int IDX_W   = 8;
    localparam int RAND_W  = 7;
    localparam int COLOR_W = 8;
    localparam int CT_W    = 9;
    localparam int LEVEL_W = 7;

    // per-slot state
    localparam int SLOT_COUNT = 32;
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int IDX_RANGE  = 1 << IDX_W;

    localparam logic [CT_W-1:0]    CT_RESET  = CT_W'(50);
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(100);
    localparam logic [RAND_W-1:0]  RAND_MOD  = RAND_W'(100);

    // r * cycle_time < 100 * 512
    localparam int PROD_W  = 16;
    // floor(x / 100) for any 16-bit x: x * 83887 >> 23 is exact below 91180
    localparam int DIVQ_W        = 10;
    localparam int DIV_MUL_W     = 17;
    localparam int DIV100_SHIFT  = 23;
    localparam logic [DIV_MUL_W-1:0] DIV100_MUL = DIV_MUL_W'(83887);
    // (c - c/2) * level < 129 * 101
    localparam int BPROD_W = 14;

    // front register + queue + back work item + output register
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
    localparam int PIPE_CAPACITY = QUEUE_DEPTH + 3;
    localparam int PEND_W        = $clog2(PIPE_CAPACITY + 1);

    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [LEVEL_W-1:0] level_t;
    typedef logic [COLOR_W-1:0] color_t;

    typedef struct packed {
        logic   falling;
        level_t level;
    } slot_state_t;

    typedef struct packed {
        slot_t             slot;
        logic [PROD_W-1:0] prod;
        color_t            red;
        color_t            green;
        color_t            blue;
    } q_entry_t;

    typedef slot_t slot_lut_t [IDX_RANGE];

    // led_index -> slot, built at elaboration
    function automatic slot_lut_t build_slot_lut();
        slot_lut_t lut;
        for (int i = 0; i < IDX_RANGE; i++)
        begin
            lut[i] = slot_t'(i % SLOT_COUNT);
        end
        return lut;
    endfunction

    localparam slot_lut_t SLOT_LUT = build_slot_lut();

    // random draws 100..127 fold back once
    function automatic logic [RAND_W-1:0] mod100(input logic [RAND_W-1:0] r);
        return (r >= RAND_MOD) ? RAND_W'(r - RAND_MOD) : r;
    endfunction

    // exact floor(x / 100) by reciprocal multiply
    function automatic logic [DIVQ_W-1:0] div100(input logic [PROD_W-1:0] x);
        logic [PROD_W+DIV_MUL_W-1:0] p;
        p = {{DIV_MUL_W{1'b0}}, x} * {{PROD_W{1'b0}}, DIV100_MUL};
        return p[DIV100_SHIFT +: DIVQ_W];
    endfunction

endpackage

// ===== rtl/core/ljb_if.sv =====
// Valid/ready channel interfaces for the jitter blend core.
// Depends on ljb_pkg for field widths.
interface ljb_in_if;
    logic                         valid;
    logic                         ready;
    logic [ljb_pkg::IDX_W-1:0]    led_index;
    logic [ljb_pkg::RAND_W-1:0]   random_value;
    logic [ljb_pkg::COLOR_W-1:0]  red_in;
    logic [ljb_pkg::COLOR_W-1:0]  green_in;
    logic [ljb_pkg::COLOR_W-1:0]  blue_in;

    modport source (output valid, led_index, random_value, red_in, green_in, blue_in,
                    input ready);
    modport sink   (input valid, led_index, random_value, red_in, green_in, blue_in,
                    output ready);
endinterface

interface ljb_out_if;
    logic                         valid;
    logic                         ready;
    logic [ljb_pkg::COLOR_W-1:0]  red_out;
    logic [ljb_pkg::COLOR_W-1:0]  green_out;
    logic [ljb_pkg::COLOR_W-1:0]  blue_out;

    modport source (output valid, red_out, green_out, blue_out, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

// ===== rtl/core/ljb_front.sv =====
// Front end: accepts items, maps slot, folds the draw and forms draw * cycle_time.
// Depends on ljb_pkg and ljb_in_if; holds the cycle_time register.
module ljb_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [ljb_pkg::CT_W-1:0]    cfg_wr_data,
    ljb_in_if.sink                      request,
    output logic                        push_valid,
    output ljb_pkg::q_entry_t           push_data,
    input  logic                        push_ready
);

    logic [ljb_pkg::CT_W-1:0]   ct_reg;
    logic                       fv_reg;
    logic                       fv_next;
    ljb_pkg::q_entry_t          fe_reg;
    logic                       in_fire;
    logic [ljb_pkg::RAND_W-1:0] r_mod;

    assign request.ready = !fv_reg || push_ready;
    assign in_fire       = request.valid && request.ready;
    assign r_mod         = ljb_pkg::mod100(request.random_value);

    assign push_valid = fv_reg;
    assign push_data  = fe_reg;

    always_comb
    begin
        fv_next = fv_reg;
        if (in_fire)
        begin
            fv_next = 1'b1;
        end
        else if (push_ready)
        begin
            fv_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ct_reg <= ljb_pkg::CT_RESET;
            fv_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                ct_reg <= cfg_wr_data;
            end
            fv_reg <= fv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            fe_reg.slot  <= ljb_pkg::SLOT_LUT[request.led_index];
            fe_reg.prod  <= ljb_pkg::PROD_W'(
                                {{(ljb_pkg::PROD_W-ljb_pkg::RAND_W){1'b0}}, r_mod}
                              * {{(ljb_pkg::PROD_W-ljb_pkg::CT_W){1'b0}}, ct_reg});
            fe_reg.red   <= request.red_in;
            fe_reg.green <= request.green_in;
            fe_reg.blue  <= request.blue_in;
        end
    end

endmodule

// ===== rtl/core/ljb_queue.sv =====
// Small FIFO that decouples the front end from the back end.
// Depends on ljb_pkg for the entry type and depth.
module ljb_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    input  ljb_pkg::q_entry_t   push_data,
    output logic                push_ready,
    output logic                pop_valid,
    output ljb_pkg::q_entry_t   pop_data,
    input  logic                pop_ready
);

    ljb_pkg::q_entry_t              q_mem [ljb_pkg::QUEUE_DEPTH];
    logic [ljb_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [ljb_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [ljb_pkg::QCNT_W-1:0]     cnt_reg;
    logic                           push_fire;
    logic                           pop_fire;

    assign push_ready = (cnt_reg != ljb_pkg::QCNT_W'(ljb_pkg::QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = q_mem[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    function automatic logic [ljb_pkg::QPTR_W-1:0] ptr_inc(
        input logic [ljb_pkg::QPTR_W-1:0] p);
        return (p == ljb_pkg::QPTR_W'(ljb_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                   : ljb_pkg::QPTR_W'(p + 1'b1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push_fire)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop_fire)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            case ({push_fire, pop_fire})
                2'b10:   cnt_reg <= ljb_pkg::QCNT_W'(cnt_reg + 1'b1);
                2'b01:   cnt_reg <= ljb_pkg::QCNT_W'(cnt_reg - 1'b1);
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            q_mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/ljb_back.sv =====
// Back end: step scaling, per-slot level read-modify-write, color blend, output register.
// Depends on ljb_pkg and ljb_out_if; owns the slot state memory.
module ljb_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    input  ljb_pkg::q_entry_t   pop_data,
    output logic                pop_ready,
    ljb_out_if.source           result
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_STEP = 5'b00010,
        ST_UPD  = 5'b00100,
        ST_MUL  = 5'b01000,
        ST_DIV  = 5'b10000
    } back_state_t;

    back_state_t                    state_reg;
    back_state_t                    state_next;
    ljb_pkg::q_entry_t              work_reg;
    ljb_pkg::slot_state_t           slot_mem [ljb_pkg::SLOT_COUNT];
    logic [ljb_pkg::SLOT_COUNT-1:0] valid_reg;
    ljb_pkg::slot_state_t           rd_data_reg;
    logic                           rd_valid_reg;
    logic [ljb_pkg::DIVQ_W-1:0]     step_reg;
    ljb_pkg::level_t                level_reg;
    logic [ljb_pkg::BPROD_W-1:0]    prod_r_reg;
    logic [ljb_pkg::BPROD_W-1:0]    prod_g_reg;
    logic [ljb_pkg::BPROD_W-1:0]    prod_b_reg;
    ljb_pkg::color_t                red_reg;
    ljb_pkg::color_t                green_reg;
    ljb_pkg::color_t                blue_reg;
    logic                           out_valid_reg;

    logic                           out_load;
    logic                           pop_fire;
    logic                           wr_en;
    ljb_pkg::slot_state_t           cur;
    ljb_pkg::slot_state_t           upd;
    logic [ljb_pkg::DIVQ_W-1:0]     lvl_w;
    logic [ljb_pkg::DIVQ_W-1:0]     sum_w;

    assign out_load  = !out_valid_reg || result.ready;
    assign pop_ready = (state_reg == ST_IDLE) || ((state_reg == ST_DIV) && out_load);
    assign pop_fire  = pop_valid && pop_ready;
    assign wr_en     = (state_reg == ST_UPD);

    assign result.valid     = out_valid_reg;
    assign result.red_out   = red_reg;
    assign result.green_out = green_reg;
    assign result.blue_out  = blue_reg;

    // unwritten slots read as level 0, rising
    assign cur   = rd_valid_reg ? rd_data_reg : '0;
    assign lvl_w = {{(ljb_pkg::DIVQ_W-ljb_pkg::LEVEL_W){1'b0}}, cur.level};
    assign sum_w = ljb_pkg::DIVQ_W'(lvl_w + step_reg);

    always_comb
    begin
        upd = cur;
        if (!cur.falling)
        begin
            if (sum_w > {{(ljb_pkg::DIVQ_W-ljb_pkg::LEVEL_W){1'b0}}, ljb_pkg::LEVEL_MAX})
            begin
                upd.level   = ljb_pkg::LEVEL_MAX;
                upd.falling = 1'b1;
            end
            else
            begin
                upd.level = sum_w[ljb_pkg::LEVEL_W-1:0];
            end
        end
        else
        begin
            if (step_reg > lvl_w)
            begin
                upd.level   = '0;
                upd.falling = 1'b0;
            end
            else
            begin
                upd.level = ljb_pkg::LEVEL_W'(lvl_w - step_reg);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (pop_valid) state_next = ST_STEP;
            ST_STEP: state_next = ST_UPD;
            ST_UPD:  state_next = ST_MUL;
            ST_MUL:  state_next = ST_DIV;
            ST_DIV:
            begin
                if (out_load)
                begin
                    state_next = pop_valid ? ST_STEP : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // (c - floor(c/2)) * level
    function automatic logic [ljb_pkg::BPROD_W-1:0] blend_mul(input ljb_pkg::color_t c,
                                                             input ljb_pkg::level_t lv);
        ljb_pkg::color_t d;
        d = ljb_pkg::COLOR_W'(c - (c >> 1));
        return ljb_pkg::BPROD_W'(
                   {{(ljb_pkg::BPROD_W-ljb_pkg::COLOR_W){1'b0}}, d}
                 * {{(ljb_pkg::BPROD_W-ljb_pkg::LEVEL_W){1'b0}}, lv});
    endfunction

    // floor(c/2) + floor(p/100)
    function automatic ljb_pkg::color_t blend_fin(input ljb_pkg::color_t c,
                                                  input logic [ljb_pkg::BPROD_W-1:0] p);
        logic [ljb_pkg::DIVQ_W-1:0] q;
        q = ljb_pkg::div100({{(ljb_pkg::PROD_W-ljb_pkg::BPROD_W){1'b0}}, p});
        return ljb_pkg::COLOR_W'((c >> 1) + q[ljb_pkg::COLOR_W-1:0]);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop_fire)
            begin
                rd_valid_reg <= valid_reg[pop_data.slot];
            end
            if (wr_en)
            begin
                valid_reg[work_reg.slot] <= 1'b1;
            end
            if ((state_reg == ST_DIV) && out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // slot state memory: one read at pop, one write in the update cycle
    always_ff @(posedge clk)
    begin
        if (pop_fire)
        begin
            rd_data_reg <= slot_mem[pop_data.slot];
        end
        if (wr_en)
        begin
            slot_mem[work_reg.slot] <= upd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_fire)
        begin
            work_reg <= pop_data;
        end
        if (state_reg == ST_STEP)
        begin
            step_reg <= ljb_pkg::div100(work_reg.prod);
        end
        if (state_reg == ST_UPD)
        begin
            level_reg <= upd.level;
        end
        if (state_reg == ST_MUL)
        begin
            prod_r_reg <= blend_mul(work_reg.red, level_reg);
            prod_g_reg <= blend_mul(work_reg.green, level_reg);
            prod_b_reg <= blend_mul(work_reg.blue, level_reg);
        end
        if ((state_reg == ST_DIV) && out_load)
        begin
            red_reg   <= blend_fin(work_reg.red, prod_r_reg);
            green_reg <= blend_fin(work_reg.green, prod_g_reg);
            blue_reg  <= blend_fin(work_reg.blue, prod_b_reg);
        end
    end

endmodule

// ===== rtl/core/led_jitter_blend_core.sv =====
// Top level of the per-LED jitter blend core.
// Depends on ljb_pkg, ljb_if, ljb_front, ljb_queue and ljb_back.
//
//  channel   | dir | handshake     | payload
//  ----------+-----+---------------+------------------------------------------
//  request   | in  | valid/ready   | led_index, random_value, red/green/blue_in
//  result    | out | valid/ready   | red_out, green_out, blue_out
//  cfg       | in  | cfg_wr_en     | cfg_wr_data = cycle_time (9 bits)
//
// Steps: the back end takes each item through its steps (step divide, slot update,
//   blend multiply, blend divide) and takes the next item only in its last step or when idle.
//   Accepted items pass the front register, queue, these steps and output register.
// Reset: asynchronous, clears cycle_time to 50, all pipeline valids and the
//   per-slot valid bits; no clearing pass is needed.
// Stalls: a stalled result holds the back end in its final step; the queue
//   and front register keep taking items until 5 are in flight.
module led_jitter_blend_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [ljb_pkg::CT_W-1:0]    cfg_wr_data,
    ljb_in_if.sink                      request,
    ljb_out_if.source                   result
);

    // front -> queue
    logic               f_push_valid;
    ljb_pkg::q_entry_t  f_push_data;
    logic               f_push_ready;

    // queue -> back
    logic               q_pop_valid;
    ljb_pkg::q_entry_t  q_pop_data;
    logic               q_pop_ready;

    // slot lookup, draw fold and draw * cycle_time
    ljb_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .request     (request),
        .push_valid  (f_push_valid),
        .push_data   (f_push_data),
        .push_ready  (f_push_ready)
    );

    // two-entry decoupling queue
    ljb_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_push_valid),
        .push_data  (f_push_data),
        .push_ready (f_push_ready),
        .pop_valid  (q_pop_valid),
        .pop_data   (q_pop_data),
        .pop_ready  (q_pop_ready)
    );

    // slot state read-modify-write and color blend; one item at a time,
    // so the next read always sees the previous write
    ljb_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (q_pop_valid),
        .pop_data  (q_pop_data),
        .pop_ready (q_pop_ready),
        .result    (result)
    );

endmodule

// ===== rtl/core/ljb_checker.sv =====
// Port-level checker for the jitter blend core, bound to the top level.
// Depends on ljb_pkg and led_jitter_blend_core_assert.svh.
`include "led_jitter_blend_core_assert.svh"

module ljb_checker
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [ljb_pkg::COLOR_W-1:0]  red_out,
    input logic [ljb_pkg::COLOR_W-1:0]  green_out,
    input logic [ljb_pkg::COLOR_W-1:0]  blue_out
);

    logic [ljb_pkg::PEND_W-1:0]     pend_reg;
    logic                           in_fire;
    logic                           out_fire;
    logic [3*ljb_pkg::COLOR_W-1:0]  rgb_out;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;
    assign rgb_out  = {red_out, green_out, blue_out};

    // items accepted and not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            case ({in_fire, out_fire})
                2'b10:   pend_reg <= ljb_pkg::PEND_W'(pend_reg + 1'b1);
                2'b01:   pend_reg <= ljb_pkg::PEND_W'(pend_reg - 1'b1);
                default: pend_reg <= pend_reg;
            endcase
        end
    end

    `LJB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    `LJB_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(rgb_out))
    `LJB_ASSERT_IMPL(a_no_phantom, out_valid, pend_reg != '0)
    `LJB_ASSERT_IMPL(a_capacity, pend_reg == ljb_pkg::PEND_W'(ljb_pkg::PIPE_CAPACITY), !in_ready)

endmodule

bind led_jitter_blend_core ljb_checker u_ljb_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (request.valid),
    .in_ready  (request.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .red_out   (result.red_out),
    .green_out (result.green_out),
    .blue_out  (result.blue_out)
);

// ===== tb/led_jitter_blend_core_tb.sv =====
// Self-checking testbench for led_jitter_blend_core: random per-LED jitter items,
// random idling on both channels and a bit-exact in-bench predictor.
// Depends on ljb_pkg, ljb_if (ljb_in_if, ljb_out_if) and led_jitter_blend_core.
module led_jitter_blend_core_tb;

    // margin over the idle accept-to-result latency, used as a pause before register writes
    localparam int LATENCY_PAUSE = 12;
    localparam int TAIL_CYCLES   = 24;
    localparam int QUIET_LIMIT   = 2000;
    localparam int MAX_WAIT      = 16;
    localparam int PHASE_ITEMS   = 197;

    // one request item plus the idle cycles the sender spends before it
    typedef struct packed {
        logic [ljb_pkg::IDX_W-1:0]  led;
        logic [ljb_pkg::RAND_W-1:0] rnd;
        ljb_pkg::color_t            red;
        ljb_pkg::color_t            green;
        ljb_pkg::color_t            blue;
        logic [4:0]                 gap;
    } jig_req_t;

    typedef struct packed {
        ljb_pkg::color_t red;
        ljb_pkg::color_t green;
        ljb_pkg::color_t blue;
    } rgb_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [ljb_pkg::CT_W-1:0] cfg_wr_data;

    ljb_in_if  req_ch ();
    ljb_out_if res_ch ();

    led_jitter_blend_core dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .request     (req_ch),
        .result      (res_ch)
    );

    // ---------------------------------------------------------------
    // Predictor state: mirror of the per-slot level/direction store and
    // of the cycle_time register. Updated only on accepted items and on
    // register writes (which happen with the block idle).
    // ---------------------------------------------------------------
    ljb_pkg::level_t          slot_level [ljb_pkg::SLOT_COUNT];
    logic                     slot_falling [ljb_pkg::SLOT_COUNT];
    logic [ljb_pkg::CT_W-1:0] cycle_time_m;

    jig_req_t pending_req_q [$];
    rgb_t     expected_rgb_q [$];
    jig_req_t cur_req;

    int unsigned send_idle;
    int unsigned sink_wait;
    int unsigned results_seen;
    int unsigned mismatches;
    int unsigned quiet_cycles;
    logic        send_burst;
    logic        hold_burst;

    // half + floor((c - half) * level / 100), half = floor(c / 2)
    function automatic ljb_pkg::color_t blend_toward(input ljb_pkg::color_t c,
                                                     input int unsigned lvl);
        int unsigned full;
        int unsigned half;
        full = c;
        half = full / 2;
        return ljb_pkg::color_t'(half + ((full - half) * lvl) / 100);
    endfunction

    // Moves the item's slot one step and returns the blended color.
    function automatic rgb_t step_jitter(input jig_req_t q);
        int unsigned slot;
        int unsigned draw;
        int unsigned ct;
        int unsigned stride;
        int unsigned lvl;
        rgb_t        o;
        slot   = q.led % ljb_pkg::SLOT_COUNT;
        draw   = q.rnd % 100;         // draws 100..127 fold back
        ct     = cycle_time_m;        // any 9-bit value, used as given
        stride = (draw * ct) / 100;
        lvl    = slot_level[slot];
        if (!slot_falling[slot])
        begin
            lvl = lvl + stride;
            // overshoot clamps and turns; landing on 100 keeps rising
            if (lvl > 100)
            begin
                lvl = 100;
                slot_falling[slot] = 1'b1;
            end
        end
        else if (stride > lvl)
        begin
            // undershoot clamps and turns; landing on 0 keeps falling
            lvl = 0;
            slot_falling[slot] = 1'b0;
        end
        else
        begin
            lvl = lvl - stride;
        end
        slot_level[slot] = ljb_pkg::level_t'(lvl);
        o.red   = blend_toward(q.red, lvl);
        o.green = blend_toward(q.green, lvl);
        o.blue  = blend_toward(q.blue, lvl);
        return o;
    endfunction

    // ---------------------------------------------------------------
    // Clock
    // ---------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // ---------------------------------------------------------------
    // Request driver: presents queued items, honoring each item's gap.
    // valid gets exactly one nonblocking update per edge.
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        logic presenting;
        logic next_valid;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            send_idle = 0;
        end
        else
        begin
            presenting = req_ch.valid;
            if (req_ch.valid && req_ch.ready)
            begin
                expected_rgb_q.push_back(step_jitter(cur_req));
                presenting = 1'b0;
            end
            next_valid = presenting;
            if (!presenting && pending_req_q.size() != 0)
            begin
                if (send_idle >= pending_req_q[0].gap)
                begin
                    cur_req = pending_req_q.pop_front();
                    send_idle = 0;
                    next_valid = 1'b1;
                    req_ch.led_index    <= cur_req.led;
                    req_ch.random_value <= cur_req.rnd;
                    req_ch.red_in       <= cur_req.red;
                    req_ch.green_in     <= cur_req.green;
                    req_ch.blue_in      <= cur_req.blue;
                end
                else
                begin
                    send_idle++;
                end
            end
            req_ch.valid <= next_valid;
        end
    end

    // ---------------------------------------------------------------
    // Result monitor: checks each accepted item against the oldest
    // expectation, then stalls ready for a drawn number of cycles.
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        rgb_t exp_rgb;
        logic next_ready;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            sink_wait = 0;
        end
        else
        begin
            next_ready = res_ch.ready;
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_rgb_q.size() == 0)
                begin
                    $error("unexpected result item: red_out %0d green_out %0d blue_out %0d",
                           res_ch.red_out, res_ch.green_out, res_ch.blue_out);
                    mismatches++;
                end
                else
                begin
                    exp_rgb = expected_rgb_q.pop_front();
                    if (res_ch.red_out !== exp_rgb.red)
                    begin
                        $error("red_out: expected %0d, got %0d", exp_rgb.red, res_ch.red_out);
                        mismatches++;
                    end
                    if (res_ch.green_out !== exp_rgb.green)
                    begin
                        $error("green_out: expected %0d, got %0d",
                               exp_rgb.green, res_ch.green_out);
                        mismatches++;
                    end
                    if (res_ch.blue_out !== exp_rgb.blue)
                    begin
                        $error("blue_out: expected %0d, got %0d", exp_rgb.blue, res_ch.blue_out);
                        mismatches++;
                    end
                end
                results_seen++;
                // switch between stall-free stretches and random stalls
                if (results_seen % 40 == 0)
                    hold_burst = ($urandom_range(0, 3) == 0);
                sink_wait = hold_burst ? 0 : $urandom_range(0, MAX_WAIT);
                next_ready = (sink_wait == 0);
            end
            else if (!res_ch.ready)
            begin
                if (sink_wait > 0)
                    sink_wait--;
                next_ready = (sink_wait == 0);
            end
            res_ch.ready <= next_ready;
        end
    end

    // ---------------------------------------------------------------
    // Watchdog: too long without any accept on either channel.
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("led_jitter_blend_core_tb NOT OK");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    task automatic queue_req(input int unsigned led, input int unsigned rnd,
                             input int unsigned r, input int unsigned g, input int unsigned b);
        jig_req_t q;
        q.led   = ljb_pkg::IDX_W'(led);
        q.rnd   = ljb_pkg::RAND_W'(rnd);
        q.red   = ljb_pkg::color_t'(r);
        q.green = ljb_pkg::color_t'(g);
        q.blue  = ljb_pkg::color_t'(b);
        q.gap   = send_burst ? 5'd0 : 5'($urandom_range(0, MAX_WAIT));
        pending_req_q.push_back(q);
    endtask

    function automatic int unsigned pick_color();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // mostly legal draws, some 100..127; a third of items hammer a few
    // hot slots through different led_index aliases
    task automatic queue_random(input int unsigned n);
        int unsigned led;
        int unsigned rnd;
        for (int i = 0; i < n; i++)
        begin
            if (i % 50 == 0)
                send_burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 2) == 0)
                led = ($urandom_range(0, 7) << 5) | $urandom_range(0, 3);
            else
                led = $urandom_range(0, 255);
            if ($urandom_range(0, 7) == 0)
                rnd = $urandom_range(100, 127);
            else
                rnd = $urandom_range(0, 99);
            queue_req(led, rnd, pick_color(), pick_color(), pick_color());
        end
    endtask

    // every queued item sent and every expected result received
    task automatic drain();
        while (pending_req_q.size() != 0 || req_ch.valid || expected_rgb_q.size() != 0)
            @(posedge clk);
    endtask

    // register write with the block idle; predictor follows the write
    task automatic write_cycle_time(input int unsigned ct);
        drain();
        repeat (LATENCY_PAUSE) @(posedge clk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_data  <= ljb_pkg::CT_W'(ct);
        cycle_time_m = ljb_pkg::CT_W'(ct);
        @(posedge clk);
        cfg_wr_en    <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        rst_n               = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_wr_data         = '0;
        req_ch.valid        = 1'b0;
        req_ch.led_index    = '0;
        req_ch.random_value = '0;
        req_ch.red_in       = '0;
        req_ch.green_in     = '0;
        req_ch.blue_in      = '0;
        res_ch.ready        = 1'b0;
        mismatches          = 0;
        results_seen        = 0;
        quiet_cycles        = 0;
        send_burst          = 1'b0;
        hold_burst          = 1'b0;
        cycle_time_m        = ljb_pkg::CT_RESET;
        for (int i = 0; i < ljb_pkg::SLOT_COUNT; i++)
        begin
            slot_level[i]   = '0;
            slot_falling[i] = 1'b0;
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part at the reset cycle_time of 50 (step = draw / 2).
        // slot 5 through aliases 5, 37, 69, 101, 133, 165, 197, 229
        queue_req(5,   99, 255, 255, 255);   // 49
        queue_req(37,  99, 0,   0,   0);     // 98
        queue_req(69,  4,  1,   254, 128);   // exactly 100, still rising
        queue_req(229, 2,  255, 0,   255);   // past the top: clamp, turn down
        queue_req(5,   99, 127, 128, 254);   // 51
        queue_req(101, 99, 255, 1,   0);     // 2
        queue_req(133, 4,  254, 255, 1);     // exactly 0, still falling
        queue_req(165, 2,  255, 255, 255);   // past the bottom: clamp, turn up
        queue_req(197, 0,  255, 128, 0);     // zero step
        // first and last slot, out-of-range draws
        queue_req(0,   127, 255, 255, 255);  // draw 27
        queue_req(255, 100, 255, 1,   0);    // draw folds to 0
        queue_req(32,  127, 0,   255, 1);
        queue_req(31,  99,  254, 127, 128);
        queue_req(64,  126, 128, 0,   255);
        // slot 9: far overshoot then undershoot from mid level
        queue_req(9,   99,  200, 100, 50);
        queue_req(9,   99,  255, 255, 255);
        queue_req(9,   99,  255, 255, 255);  // 147 clamps to 100
        queue_req(41,  99,  3,   2,   1);    // 51
        queue_req(73,  127, 255, 0,   255);  // 38
        queue_req(105, 99,  255, 255, 255);  // 49 > 38: clamp to 0

        queue_random(PHASE_ITEMS);

        // cycle_time sweep, extremes 0 and 511 included
        write_cycle_time(300);
        queue_random(PHASE_ITEMS);
        write_cycle_time(0);
        queue_random(PHASE_ITEMS / 2);
        write_cycle_time(511);
        queue_random(PHASE_ITEMS);
        write_cycle_time(50);
        queue_random(PHASE_ITEMS);
        write_cycle_time($urandom_range(50, 300));
        queue_random(PHASE_ITEMS);
        write_cycle_time($urandom_range(0, 511));
        queue_random(PHASE_ITEMS);

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_rgb_q.size() != 0)
        begin
            $error("%0d result items never arrived", expected_rgb_q.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("led_jitter_blend_core_tb OK");
        else
            $display("led_jitter_blend_core_tb NOT OK");
        $finish;
    end

endmodule

// ===== led_jitter_blend_core.f =====
+incdir+rtl/core
rtl/core/ljb_pkg.sv
rtl/core/ljb_if.sv
rtl/core/ljb_front.sv
rtl/core/ljb_queue.sv
rtl/core/ljb_back.sv
rtl/core/led_jitter_blend_core.sv
rtl/core/ljb_checker.sv
tb/led_jitter_blend_core_tb.sv
